### src/multi_channel_watchdog_monitor_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the multi-channel watchdog monitor
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef MULTI_CHANNEL_WATCHDOG_MONITOR_MACROS_SVH
`define MULTI_CHANNEL_WATCHDOG_MONITOR_MACROS_SVH

`ifndef SYNTHESIS

// Check that cons holds in the same cycle as ante
`define MCWDM_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mcwdm: assertion failed");

// Check that cons holds in the cycle after ante
`define MCWDM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mcwdm: assertion failed");

`else

`define MCWDM_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define MCWDM_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### src/mcwdm_pkg.sv
// ----------------------------------------------------------------------------
// Multi-channel watchdog monitor package
// Shared widths, codes, payload structs and controller/datapath links.
// ----------------------------------------------------------------------------
package mcwdm_pkg;

    localparam int NUM_CHANNELS_DEF = 8;
    localparam int TIME_W           = 32;
    localparam int CHAN_W           = 3;
    localparam int ACT_W            = 3;
    localparam int ST_W             = 2;

    // System watchdog timeout in seconds; deadline bound is half of it in ms
    localparam int WDT_TIMEOUT_S = 5;
    localparam logic [TIME_W-1:0] DEFAULT_MIN_PERIOD_MS =
        TIME_W'((WDT_TIMEOUT_S * 1000) / 2);

    // Action codes
    localparam logic [ACT_W-1:0] ACT_CHECK   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_FEED    = 3'd1;
    localparam logic [ACT_W-1:0] ACT_ENABLE  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_DISABLE = 3'd3;
    localparam logic [ACT_W-1:0] ACT_CREATE  = 3'd4;
    localparam logic [ACT_W-1:0] ACT_DELETE  = 3'd5;

    // Result status codes
    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_TIMEOUT = 2'd1;
    localparam logic [ST_W-1:0] ST_ABSENT  = 2'd2;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [CHAN_W-1:0] channel;
        logic [TIME_W-1:0] new_period_ms;
        logic [TIME_W-1:0] now_ms;
    } wdm_item_t;

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [CHAN_W-1:0] timed_out_channel;
        logic [TIME_W-1:0] deadline_left_ms;
        logic              kick_system;
    } wdm_result_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;       // capture the input transfer and arm the scan
        logic scan_step;  // issue the next channel read of a check
        logic op_read;    // read the addressed channel
        logic exec;       // apply a channel action and form its result
        logic finish;     // form the result of a check
        logic push;       // move the result into the output register
    } ctrl_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic item_is_check;
        logic scan_done;
        logic out_free;
    } ctrl_stat_t;

endpackage

### src/mcwdm_ctrl.sv
// ----------------------------------------------------------------------------
// Watchdog monitor controller
// Sequences one transfer at a time: channel scan for a check, read, compute
// and execute for channel actions, then hand the result to the output stage.
// ----------------------------------------------------------------------------
module mcwdm_ctrl
    import mcwdm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    input  ctrl_stat_t stat,
    output logic       item_stall,
    output ctrl_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_OP_READ,
        S_OP_CALC,
        S_OP_EXEC,
        S_PUSH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   busy_next;

    // Decode next state and issue commands
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = stat.item_is_check ? S_SCAN : S_OP_READ;
                end
            end
            S_SCAN:
            begin
                if (stat.scan_done)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_PUSH;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_OP_READ:
            begin
                cmd.op_read = 1'b1;
                state_next  = S_OP_CALC;
            end
            S_OP_CALC:
            begin
                state_next = S_OP_EXEC;
            end
            S_OP_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = S_PUSH;
            end
            S_PUSH:
            begin
                if (stat.out_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        busy_next = (state_next != S_IDLE);
    end

    // Hold state and the registered stall
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
        end
    end

    assign item_stall = busy_reg;

endmodule

### src/mcwdm_dpath.sv
// ----------------------------------------------------------------------------
// Watchdog monitor datapath
// Channel tables, scan pipeline, action execution and output register.
// ----------------------------------------------------------------------------
module mcwdm_dpath
    import mcwdm_pkg::*;
#(
    parameter int CHANNELS = NUM_CHANNELS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  wdm_item_t         item,
    input  logic              cfg_wr_en,
    input  logic [TIME_W-1:0] cfg_wr_data,
    input  ctrl_cmd_t         cmd,
    output ctrl_stat_t        stat,
    input  logic              result_stall,
    output logic              result_valid,
    output wdm_result_t       result
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CNT_W = $clog2(CHANNELS + 1);

    // Channel tables
    logic [TIME_W-1:0]   period_mem [CHANNELS];
    logic [TIME_W-1:0]   last_mem   [CHANNELS];
    logic [CHANNELS-1:0] en_reg;
    logic [CHANNELS-1:0] en_next;
    logic [CHANNELS-1:0] pres_reg;
    logic [CHANNELS-1:0] pres_next;
    logic [TIME_W-1:0]   min_reg;

    // Captured transfer and channel decode
    wdm_item_t         item_reg;
    logic [31:0]       ch_wide;
    logic [IDX_W-1:0]  ch_idx;
    logic              ch_ok;

    // Scan pipeline: read, compute, compare
    logic [CNT_W-1:0]  scan_idx_reg;
    logic              issue;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              v1_reg;
    logic              v2_reg;
    logic [IDX_W-1:0]  idx1_reg;
    logic [IDX_W-1:0]  idx2_reg;
    logic [TIME_W-1:0] rd_period_reg;
    logic [TIME_W-1:0] rd_last_reg;
    logic [TIME_W-1:0] elapsed;
    logic [TIME_W:0]   diff;
    logic              exp_reg;
    logic              elig_reg;
    logic [TIME_W-1:0] rem_reg;
    logic              found_reg;
    logic [IDX_W-1:0]  tch_idx_reg;
    logic [31:0]       tch_wide;
    logic [TIME_W-1:0] best_reg;

    // Action execution
    logic              wr_period;
    logic              wr_last;
    logic [TIME_W-1:0] last_wdata;
    logic              min_lower;
    wdm_result_t       res_next;
    wdm_result_t       res_reg;
    wdm_result_t       out_reg;
    logic              out_valid_reg;

    // Decode the addressed channel
    assign ch_wide = 32'(item_reg.channel);
    assign ch_idx  = ch_wide[IDX_W-1:0];
    assign ch_ok   = (ch_wide < 32'(CHANNELS));

    // Select the table read address
    assign issue   = cmd.scan_step && (scan_idx_reg < CNT_W'(CHANNELS));
    assign rd_en   = issue || cmd.op_read;
    assign rd_addr = issue ? scan_idx_reg[IDX_W-1:0] : ch_idx;

    // Remaining time: expired when the wrapping elapsed time reaches the period
    assign elapsed = item_reg.now_ms - rd_last_reg;
    assign diff    = {1'b0, rd_period_reg} - {1'b0, elapsed};

    assign tch_wide = 32'(tch_idx_reg);

    // Form results and table updates
    always_comb
    begin
        res_next   = '0;
        en_next    = en_reg;
        pres_next  = pres_reg;
        wr_period  = 1'b0;
        wr_last    = 1'b0;
        last_wdata = item_reg.now_ms;
        min_lower  = 1'b0;
        if (cmd.finish)
        begin
            if (found_reg)
            begin
                res_next.status            = ST_TIMEOUT;
                res_next.timed_out_channel = tch_wide[CHAN_W-1:0];
            end
            else
            begin
                res_next.status           = ST_OK;
                res_next.deadline_left_ms = best_reg;
                res_next.kick_system      = 1'b1;
            end
        end
        else if (cmd.exec)
        begin
            case (item_reg.action)
                ACT_CREATE:
                begin
                    if (!ch_ok)
                    begin
                        res_next.status = ST_ABSENT;
                    end
                    else
                    begin
                        wr_period         = 1'b1;
                        wr_last           = 1'b1;
                        last_wdata        = '0;
                        en_next[ch_idx]   = 1'b0;
                        pres_next[ch_idx] = 1'b1;
                        min_lower         = (item_reg.new_period_ms < min_reg);
                    end
                end
                ACT_FEED, ACT_ENABLE, ACT_DISABLE, ACT_DELETE:
                begin
                    if (!ch_ok || !pres_reg[ch_idx])
                    begin
                        res_next.status = ST_ABSENT;
                    end
                    else
                    begin
                        case (item_reg.action)
                            ACT_FEED:
                            begin
                                if (en_reg[ch_idx] && exp_reg)
                                begin
                                    res_next.status            = ST_TIMEOUT;
                                    res_next.timed_out_channel = item_reg.channel;
                                end
                                else
                                begin
                                    wr_last = 1'b1;
                                end
                            end
                            ACT_ENABLE:
                            begin
                                wr_last         = 1'b1;
                                en_next[ch_idx] = 1'b1;
                            end
                            ACT_DISABLE:
                            begin
                                en_next[ch_idx] = 1'b0;
                            end
                            default:
                            begin
                                en_next[ch_idx]   = 1'b0;
                                pres_next[ch_idx] = 1'b0;
                            end
                        endcase
                    end
                end
                default:
                begin
                    // Unused action codes leave an all-zero result
                end
            endcase
        end
    end

    // Write and read the channel tables
    always_ff @(posedge clk)
    begin
        if (wr_period)
        begin
            period_mem[ch_idx] <= item_reg.new_period_ms;
        end
        if (wr_last)
        begin
            last_mem[ch_idx] <= last_wdata;
        end
        if (rd_en)
        begin
            rd_period_reg <= period_mem[rd_addr];
            rd_last_reg   <= last_mem[rd_addr];
            idx1_reg      <= rd_addr;
        end
    end

    // Advance the payload side of the pipeline
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= item;
            best_reg <= min_reg;
        end
        else if (v2_reg && elig_reg && !found_reg && !exp_reg && (rem_reg < best_reg))
        begin
            best_reg <= rem_reg;
        end
        if (v2_reg && elig_reg && !found_reg && exp_reg)
        begin
            tch_idx_reg <= idx2_reg;
        end
        exp_reg  <= diff[TIME_W] || (diff[TIME_W-1:0] == '0);
        rem_reg  <= diff[TIME_W-1:0];
        idx2_reg <= idx1_reg;
        elig_reg <= pres_reg[idx1_reg] && en_reg[idx1_reg];
        if (cmd.finish || cmd.exec)
        begin
            res_reg <= res_next;
        end
        if (cmd.push)
        begin
            out_reg <= res_reg;
        end
    end

    // Hold control state, flags and the deadline bound
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg        <= '0;
            pres_reg      <= '0;
            min_reg       <= DEFAULT_MIN_PERIOD_MS;
            scan_idx_reg  <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            en_reg   <= en_next;
            pres_reg <= pres_next;
            if (cfg_wr_en)
            begin
                min_reg <= cfg_wr_data;
            end
            else if (min_lower)
            begin
                min_reg <= item_reg.new_period_ms;
            end
            if (cmd.load)
            begin
                scan_idx_reg <= '0;
                found_reg    <= 1'b0;
            end
            else
            begin
                if (issue)
                begin
                    scan_idx_reg <= scan_idx_reg + 1'b1;
                end
                if (v2_reg && elig_reg && exp_reg)
                begin
                    found_reg <= 1'b1;
                end
            end
            v1_reg <= issue;
            v2_reg <= v1_reg;
            if (cmd.push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Report to the controller
    assign stat.item_is_check = (item.action == ACT_CHECK);
    assign stat.scan_done     = !(scan_idx_reg < CNT_W'(CHANNELS)) && !v1_reg && !v2_reg;
    assign stat.out_free      = !out_valid_reg || !result_stall;

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

### src/multi_channel_watchdog_monitor.sv
// ----------------------------------------------------------------------------
// Multi-channel watchdog monitor
// Table of software watchdog channels checked against a millisecond clock.
// ----------------------------------------------------------------------------
// Input channel item/item_valid/item_stall carries one action with the current
// time; output channel result/result_valid/result_stall returns exactly one
// result per input transfer, in order. cfg_wr_en/cfg_wr_data load the default
// deadline bound, which also reloads the running minimum period; write it only
// while the block is idle.
// One transfer is in work at a time; item_stall is high while it runs.
// A check walks the channel table one entry per cycle through a three-stage
// read/compute/compare pipeline. Feed, enable, disable, create and delete go
// through table read, remaining-time compute, execute and output handoff.
// The output register lets the next transfer be accepted while a result waits;
// with the receiver stalling, work stops at the handoff until the slot frees.
// Reset clears all present and enabled flags and the output valid, and sets
// the minimum period to 2500 ms. Period and feed-time tables are not cleared;
// a channel is always created before its entries are used.
// ----------------------------------------------------------------------------
`include "multi_channel_watchdog_monitor_macros.svh"

module multi_channel_watchdog_monitor
    import mcwdm_pkg::*;
#(
    parameter int CHANNELS = NUM_CHANNELS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  wdm_item_t         item,
    output logic              result_valid,
    input  logic              result_stall,
    output wdm_result_t       result,
    input  logic              cfg_wr_en,
    input  logic [TIME_W-1:0] cfg_wr_data
);

    ctrl_cmd_t  cmd;
    ctrl_stat_t stat;

    // Sequence each transfer
    mcwdm_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .stat       (stat),
        .item_stall (item_stall),
        .cmd        (cmd)
    );

    // Hold the channel tables and compute results
    mcwdm_dpath #(
        .CHANNELS (CHANNELS)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .cmd          (cmd),
        .stat         (stat),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .result       (result)
    );

    // Go busy right after a transfer is taken
    `MCWDM_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, item_valid && !item_stall, item_stall)
    // Push only into a free output slot
    `MCWDM_ASSERT_IMPLY(a_push_into_free, clk, rst_n, cmd.push, stat.out_free)
    // Issue at most one sequencing command per cycle
    `MCWDM_ASSERT_IMPLY(a_one_command, clk, rst_n, 1'b1, $onehot0({cmd.load, cmd.op_read, cmd.exec, cmd.finish, cmd.push}))
    // Kick the system watchdog only with an ok status
    `MCWDM_ASSERT_IMPLY(a_kick_is_ok, clk, rst_n, result_valid && result.kick_system, result.status == ST_OK)

endmodule

### bench/multi_channel_watchdog_monitor_test.sv
// ----------------------------------------------------------------------------
// Multi-channel watchdog monitor testbench
// Drives action transfers with a running millisecond clock through the input
// channel and compares every result transfer, field by field, against a
// channel-table model kept in the bench. Covers directed corner cases, short
// and long periods, time wrap, random fields, output back-pressure and a
// steady stream, under several settings of the deadline bound register.
// ----------------------------------------------------------------------------
module multi_channel_watchdog_monitor_test;
    import mcwdm_pkg::*;

    localparam int                NCH            = NUM_CHANNELS_DEF;
    localparam logic [TIME_W-1:0] RESET_BOUND_MS = 32'd2500;
    localparam logic [ACT_W-1:0]  ACT_SPARE_LO   = 3'd6;
    localparam logic [ACT_W-1:0]  ACT_SPARE_HI   = 3'd7;
    localparam int                SETTLE_CYCLES  = NCH + 8;
    localparam int                HOLD_CYCLES    = 300;
    localparam int                STALL_LIMIT    = 4000;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              item_valid;
    logic              item_stall;
    wdm_item_t         item_bus;
    logic              result_valid;
    logic              result_stall;
    wdm_result_t       result_bus;
    logic              cfg_wr_en;
    logic [TIME_W-1:0] cfg_wr_data;

    // Channel table as the bench sees it
    logic [TIME_W-1:0] chan_period [NCH];
    logic [TIME_W-1:0] chan_fed_at [NCH];
    logic [NCH-1:0]    chan_enabled = '0;
    logic [NCH-1:0]    chan_present = '0;
    logic [TIME_W-1:0] deadline_cap = RESET_BOUND_MS;

    wdm_result_t       verdict_queue [$];
    logic [TIME_W-1:0] clock_ms;

    bit          tx_idle_on;
    bit          rx_idle_on;
    int          hold_request;
    int          mismatches;
    int          items_sent;
    int          bound_writes;
    int          timeouts_seen;
    int          kicks_seen;
    int          absent_seen;
    int          quiet_cycles;
    wdm_result_t want;

    multi_channel_watchdog_monitor dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item_bus),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result_bus),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data)
    );

    always #2 clk = ~clk;

    // Remaining time of a channel, zero once it has run out
    function automatic logic [TIME_W-1:0] time_left(int idx, logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] elapsed;
        elapsed = now - chan_fed_at[idx];
        return (elapsed >= chan_period[idx]) ? '0 : chan_period[idx] - elapsed;
    endfunction

    // Apply one action to the channel table and form its verdict
    task automatic predict_watchdog_verdict(input wdm_item_t it, output wdm_result_t r);
        logic [TIME_W-1:0] best;
        logic [TIME_W-1:0] left;
        int                ch;
        int                i;
        bit                found;
        r  = '0;
        ch = int'(it.channel);
        if (it.action == ACT_CHECK)
        begin
            best  = deadline_cap;
            found = 1'b0;
            for (i = 0; i < NCH && !found; i++)
            begin
                if (chan_present[i] && chan_enabled[i])
                begin
                    left = time_left(i, it.now_ms);
                    if (left == '0)
                    begin
                        found               = 1'b1;
                        r.timed_out_channel = CHAN_W'(i);
                    end
                    else if (left < best)
                    begin
                        best = left;
                    end
                end
            end
            if (found)
            begin
                r.status = ST_TIMEOUT;
            end
            else
            begin
                r.deadline_left_ms = best;
                r.kick_system      = 1'b1;
            end
        end
        else if (it.action <= ACT_DELETE)
        begin
            if (ch >= NCH)
            begin
                r.status = ST_ABSENT;
            end
            else if (it.action == ACT_CREATE)
            begin
                chan_period[ch]  = it.new_period_ms;
                chan_fed_at[ch]  = '0;
                chan_enabled[ch] = 1'b0;
                chan_present[ch] = 1'b1;
                if (it.new_period_ms < deadline_cap)
                    deadline_cap = it.new_period_ms;
            end
            else if (!chan_present[ch])
            begin
                r.status = ST_ABSENT;
            end
            else if (it.action == ACT_FEED)
            begin
                if (chan_enabled[ch] && time_left(ch, it.now_ms) == '0)
                begin
                    r.status            = ST_TIMEOUT;
                    r.timed_out_channel = it.channel;
                end
                else
                begin
                    chan_fed_at[ch] = it.now_ms;
                end
            end
            else if (it.action == ACT_ENABLE)
            begin
                chan_fed_at[ch]  = it.now_ms;
                chan_enabled[ch] = 1'b1;
            end
            else if (it.action == ACT_DISABLE)
            begin
                chan_enabled[ch] = 1'b0;
            end
            else
            begin
                chan_present[ch] = 1'b0;
                chan_enabled[ch] = 1'b0;
            end
        end
    endtask

    function automatic wdm_item_t mk(logic [ACT_W-1:0] act, logic [CHAN_W-1:0] ch,
                                     logic [TIME_W-1:0] per, logic [TIME_W-1:0] now);
        wdm_item_t it;
        it.action        = act;
        it.channel       = ch;
        it.new_period_ms = per;
        it.now_ms        = now;
        return it;
    endfunction

    // Offer one transfer, hold it until accepted, then log its verdict
    task automatic send_item(input wdm_item_t it);
        wdm_result_t r;
        @(negedge clk);
        if (tx_idle_on && $urandom_range(0, 3) == 0)
        begin
            item_valid = 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        item_bus   = it;
        item_valid = 1'b1;
        do @(posedge clk); while (item_stall);
        predict_watchdog_verdict(it, r);
        verdict_queue.push_back(r);
        items_sent++;
        if (r.status == ST_TIMEOUT) timeouts_seen++;
        if (r.status == ST_ABSENT) absent_seen++;
        if (r.kick_system) kicks_seen++;
    endtask

    // Drop valid and wait until every verdict is back and the block is quiet
    task automatic settle_block;
        @(negedge clk);
        item_valid = 1'b0;
        while (verdict_queue.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_deadline_bound(input logic [TIME_W-1:0] bound);
        settle_block;
        cfg_wr_en   = 1'b1;
        cfg_wr_data = bound;
        @(negedge clk);
        cfg_wr_en    = 1'b0;
        deadline_cap = bound;
        bound_writes++;
    endtask

    // Build one transfer: mostly well-formed actions on live channels
    task automatic pick_item(input int unsigned per_lo, input int unsigned per_hi,
                             input int unsigned step_hi, input int unsigned noise_pct,
                             output wdm_item_t it);
        int unsigned       roll;
        int                k;
        int                i;
        logic [CHAN_W-1:0] ch;
        logic [TIME_W-1:0] per;
        clock_ms += $urandom_range(0, step_hi);
        ch  = CHAN_W'($urandom);
        per = $urandom;
        if ($urandom_range(0, 99) < noise_pct)
        begin
            it = mk(ACT_W'($urandom_range(0, 7)), ch, per, $urandom);
        end
        else
        begin
            // aim most channel actions at a present channel
            if (chan_present != '0 && $urandom_range(0, 99) < 85)
            begin
                k = $urandom_range(0, $countones(chan_present) - 1);
                for (i = 0; i < NCH; i++)
                begin
                    if (chan_present[i])
                    begin
                        if (k == 0) ch = CHAN_W'(i);
                        k = k - 1;
                    end
                end
            end
            roll = $urandom_range(0, 99);
            if (roll < 30)
            begin
                it = mk(ACT_CHECK, ch, per, clock_ms);
            end
            else if (roll < 58)
            begin
                it = mk(ACT_FEED, ch, per, clock_ms);
            end
            else if (roll < 68)
            begin
                it = mk(ACT_ENABLE, ch, per, clock_ms);
            end
            else if (roll < 76)
            begin
                it = mk(ACT_DISABLE, ch, per, clock_ms);
            end
            else if (roll < 90)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 3)
                    per = '0;
                else if (roll < 6)
                    per = '1;
                else
                    per = $urandom_range(per_lo, per_hi);
                it = mk(ACT_CREATE, CHAN_W'($urandom), per, clock_ms);
            end
            else
            begin
                it = mk(ACT_DELETE, ch, per, clock_ms);
            end
        end
    endtask

    task automatic run_traffic(input int count, input int unsigned per_lo,
                               input int unsigned per_hi, input int unsigned step_hi,
                               input int unsigned noise_pct);
        wdm_item_t it;
        repeat (count)
        begin
            pick_item(per_lo, per_hi, step_hi, noise_pct, it);
            send_item(it);
        end
    endtask

    // Reset bound, every action, absent channels, wrap, index order, spare codes
    task automatic test_directed_actions;
        send_item(mk(ACT_CHECK, 3'd0, 32'd0, 32'd0));
        send_item(mk(ACT_FEED, 3'd0, 32'd0, 32'd5));
        send_item(mk(ACT_ENABLE, 3'd7, '1, 32'd6));
        send_item(mk(ACT_DISABLE, 3'd3, 32'd0, 32'd7));
        send_item(mk(ACT_DELETE, 3'd5, 32'd0, 32'd8));
        send_item(mk(ACT_CREATE, 3'd0, 32'd100, 32'd10));
        send_item(mk(ACT_CREATE, 3'd7, '1, 32'd11));
        send_item(mk(ACT_CHECK, 3'd0, 32'd0, 32'd50));
        send_item(mk(ACT_FEED, 3'd0, 32'd0, 32'd60));
        send_item(mk(ACT_ENABLE, 3'd0, 32'd0, 32'hFFFF_FFF0));
        send_item(mk(ACT_ENABLE, 3'd7, 32'd0, 32'hFFFF_FFF0));
        send_item(mk(ACT_CHECK, 3'd0, 32'd0, 32'h0000_0010));
        send_item(mk(ACT_FEED, 3'd0, 32'd0, 32'h0000_0050));
        send_item(mk(ACT_CHECK, 3'd0, 32'd0, 32'h0000_00B4));
        send_item(mk(ACT_FEED, 3'd0, 32'd0, 32'h0000_00B4));
        send_item(mk(ACT_CREATE, 3'd3, 32'd0, 32'h0000_00B5));
        send_item(mk(ACT_ENABLE, 3'd3, 32'd0, 32'h0000_00B5));
        send_item(mk(ACT_CHECK, 3'd0, 32'd0, 32'h0000_00B6));
        send_item(mk(ACT_DISABLE, 3'd0, 32'd0, 32'h0000_00B7));
        send_item(mk(ACT_CHECK, 3'd0, 32'd0, 32'h0000_00B8));
        send_item(mk(ACT_DELETE, 3'd3, 32'd0, 32'h0000_00B9));
        send_item(mk(ACT_CHECK, 3'd0, 32'd0, 32'h0000_00BA));
        send_item(mk(ACT_SPARE_LO, '1, '1, '1));
        send_item(mk(ACT_SPARE_HI, '1, '1, '1));
        send_item(mk(ACT_CREATE, 3'd0, 32'd5, 32'h0000_00BB));
    endtask

    task automatic test_short_periods;
        write_deadline_bound('1);
        clock_ms = 32'd1000;
        run_traffic(350, 5, 80, 6, 3);
    endtask

    task automatic test_time_wrap;
        write_deadline_bound($urandom);
        clock_ms = 32'hFFFF_FE00;
        run_traffic(250, 50, 2000, 40, 3);
    endtask

    // Freeze the receiver while the sender keeps offering transfers
    task automatic test_output_backpressure;
        write_deadline_bound('0);
        tx_idle_on   = 1'b0;
        hold_request = HOLD_CYCLES;
        run_traffic(60, 5, 200, 8, 5);
        tx_idle_on = 1'b1;
    endtask

    task automatic test_random_fields;
        write_deadline_bound(32'd777);
        run_traffic(150, 1, 500, 20, 60);
    endtask

    task automatic test_steady_stream;
        write_deadline_bound(32'd1000);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        clock_ms   = $urandom;
        run_traffic(340, 10, 150, 5, 3);
    endtask

    // Receiver stall: random bursts, or one long hold when requested
    initial
    begin
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                result_stall = 1'b1;
                repeat (hold_request - 1) @(negedge clk);
                hold_request = 0;
            end
            else if (rx_idle_on && $urandom_range(0, 3) == 0)
            begin
                result_stall = 1'b1;
                repeat ($urandom_range(1, 11) - 1) @(negedge clk);
            end
            else
            begin
                result_stall = 1'b0;
            end
        end
    end

    // Compare each result transfer with the oldest pending verdict
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (verdict_queue.size() == 0)
            begin
                $display("%0t: result with nothing pending, got %h", $time, result_bus);
                mismatches++;
            end
            else
            begin
                want = verdict_queue.pop_front();
                if (result_bus.status !== want.status)
                begin
                    $display("%0t: status expected %0d, got %0d",
                             $time, want.status, result_bus.status);
                    mismatches++;
                end
                if (result_bus.timed_out_channel !== want.timed_out_channel)
                begin
                    $display("%0t: timed_out_channel expected %0d, got %0d",
                             $time, want.timed_out_channel, result_bus.timed_out_channel);
                    mismatches++;
                end
                if (result_bus.deadline_left_ms !== want.deadline_left_ms)
                begin
                    $display("%0t: deadline_left_ms expected %0d, got %0d",
                             $time, want.deadline_left_ms, result_bus.deadline_left_ms);
                    mismatches++;
                end
                if (result_bus.kick_system !== want.kick_system)
                begin
                    $display("%0t: kick_system expected %0b, got %0b",
                             $time, want.kick_system, result_bus.kick_system);
                    mismatches++;
                end
            end
        end
    end

    // End the run when no transfer moves for too long
    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles, %0d verdicts pending",
                     $time, quiet_cycles, verdict_queue.size());
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item_bus     = '0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        tx_idle_on   = 1'b1;
        rx_idle_on   = 1'b1;
        hold_request = 0;
        mismatches   = 0;
        quiet_cycles = 0;
        clock_ms     = '0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        test_directed_actions;
        test_short_periods;
        test_time_wrap;
        test_output_backpressure;
        test_random_fields;
        test_steady_stream;
        settle_block;

        $display("Covered %0d transfers over %0d bound settings, all-zero and all-ones included.",
                 items_sent, bound_writes);
        $display("Verdicts: %0d timeouts, %0d system kicks, %0d absent-channel answers.",
                 timeouts_seen, kicks_seen, absent_seen);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
